[design/lir_pkg.sv]
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants for the block linear resampler
// Payload structs, configuration register map and reset values.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 16;
    localparam int RATIO_W    = 25;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_ADDR_W = 2;
    localparam int FRAC16_W   = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BLOCK_INPUTS  = 2'd0,
        REG_BLOCK_OUTPUTS = 2'd1,
        REG_RATIO_STEP    = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_reg_t;

    localparam logic [COUNT_W-1:0] BLOCK_INPUTS_RST  = 16'd2100;
    localparam logic [COUNT_W-1:0] BLOCK_OUTPUTS_RST = 16'd2048;
    localparam logic [RATIO_W-1:0] RATIO_STEP_RST    = 25'd17203200;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_i;
        logic signed [SAMPLE_W-1:0] in_q;
    } in_sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_i;
        logic signed [SAMPLE_W-1:0] out_q;
        logic                       block_last;
    } out_sample_t;

endpackage

[design/block_linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// block_linear_interp_resampler: block-wise linear interpolation resampler
// Complex I/Q rate converter; one interpolated sample per input at most.
// ----------------------------------------------------------------------------
//
//  channel  | ports                       | handshake      | payload
//  ---------+-----------------------------+----------------+----------------
//  input    | s_valid s_ready s_data      | valid / ready  | in_sample_t
//  result   | m_valid m_ready m_data      | valid / ready  | out_sample_t
//  config   | cfg_wr_en cfg_addr cfg_wdata| write enable   | 25-bit data
//
//  Throughput is one input transfer per clock while the result side is not
//  stalled. A sample passes the input register, then the result register.
//  The phase accumulate and compare loop is combinational, which sets the rate.
//  aresetn is synchronous, active low; it restores register defaults and
//  clears the block position, phase and output count.
//  A stalled result holds the result register; the input register then
//  holds its sample and s_ready drops until the result is taken.
//
module block_linear_interp_resampler #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lir_pkg::in_sample_t                  s_data,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lir_pkg::out_sample_t                 m_data,

    input  logic                                 cfg_wr_en,
    input  logic [lir_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [lir_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import lir_pkg::*;

    localparam int PHASE_W = COUNT_W + FRAC_BITS;

    // configuration registers
    logic [COUNT_W-1:0]  block_inputs_reg;
    logic [COUNT_W-1:0]  block_outputs_reg;
    logic [RATIO_W-1:0]  ratio_step_reg;

    // input stage
    logic                in_valid_reg, in_valid_next;
    in_sample_t          in_data_reg;

    // resampler state
    logic [SAMPLE_W-1:0] prev_i_reg, prev_i_next;
    logic [SAMPLE_W-1:0] prev_q_reg, prev_q_next;
    logic [COUNT_W-1:0]  block_pos_reg, block_pos_next;
    logic [PHASE_W-1:0]  phase_acc_reg, phase_acc_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // result stage
    logic                m_valid_reg, m_valid_next;
    out_sample_t         m_data_reg, m_data_next;

    logic                out_ok;
    logic                fire;
    logic                due;
    logic [COUNT_W-1:0]  phase_base;
    logic [FRAC16_W-1:0] frac;
    logic [PHASE_W:0]    phase_sum;
    logic [PHASE_W-1:0]  phase_adv;
    logic [COUNT_W-1:0]  last_index;

    logic signed [SAMPLE_W:0]            diff_i, diff_q;
    logic signed [SAMPLE_W+FRAC16_W+1:0] prod_i, prod_q;
    logic signed [SAMPLE_W+FRAC16_W+1:0] step_i, step_q;
    logic [SAMPLE_W-1:0]                 lerp_i, lerp_q;

    // ------------------------------------------------------------------
    // Handshake: the result register frees when empty or being taken;
    // the input register moves on whenever the result side frees.
    // ------------------------------------------------------------------
    assign out_ok  = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && out_ok;
    assign s_ready = !in_valid_reg || out_ok;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Configuration writes take effect at once; unmapped index is dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_inputs_reg  <= BLOCK_INPUTS_RST;
            block_outputs_reg <= BLOCK_OUTPUTS_RST;
            ratio_step_reg    <= RATIO_STEP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_BLOCK_INPUTS:  block_inputs_reg  <= cfg_wdata[COUNT_W-1:0];
                REG_BLOCK_OUTPUTS: block_outputs_reg <= cfg_wdata[COUNT_W-1:0];
                REG_RATIO_STEP:    ratio_step_reg    <= cfg_wdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Phase: integer part is the base sample index within the block,
    // fraction bits, trimmed or zero-padded to 16, weight the interpolation.
    // ------------------------------------------------------------------
    assign phase_base = phase_acc_reg[PHASE_W-1:FRAC_BITS];

    generate
        if (FRAC_BITS >= FRAC16_W) begin : g_frac_down
            assign frac = phase_acc_reg[FRAC_BITS-1 -: FRAC16_W];
        end else begin : g_frac_up
            assign frac = {phase_acc_reg[FRAC_BITS-1:0], {(FRAC16_W-FRAC_BITS){1'b0}}};
        end
    endgenerate

    // saturate at full scale instead of wrapping
    assign phase_sum = {1'b0, phase_acc_reg} + (PHASE_W+1)'(ratio_step_reg);
    assign phase_adv = phase_sum[PHASE_W] ? {PHASE_W{1'b1}} : phase_sum[PHASE_W-1:0];

    // An output is due once its base sample is at or behind the newest
    // stored sample and the block has not used up its output budget.
    assign due = (block_pos_reg != '0) && (out_count_reg < block_outputs_reg)
              && (phase_base < block_pos_reg);

    assign last_index = block_outputs_reg - COUNT_W'(1);

    // ------------------------------------------------------------------
    // Interpolate: prev + floor(frac * (cur - prev) / 2^16), per lane.
    // ------------------------------------------------------------------
    assign diff_i = $signed({in_data_reg.in_i[SAMPLE_W-1], in_data_reg.in_i})
                  - $signed({prev_i_reg[SAMPLE_W-1], prev_i_reg});
    assign diff_q = $signed({in_data_reg.in_q[SAMPLE_W-1], in_data_reg.in_q})
                  - $signed({prev_q_reg[SAMPLE_W-1], prev_q_reg});

    assign prod_i = diff_i * $signed({1'b0, frac});
    assign prod_q = diff_q * $signed({1'b0, frac});

    assign step_i = prod_i >>> FRAC16_W;
    assign step_q = prod_q >>> FRAC16_W;

    // wrap to sample width
    assign lerp_i = prev_i_reg + step_i[SAMPLE_W-1:0];
    assign lerp_q = prev_q_reg + step_q[SAMPLE_W-1:0];

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        in_valid_next  = in_valid_reg;
        prev_i_next    = prev_i_reg;
        prev_q_next    = prev_q_reg;
        block_pos_next = block_pos_reg;
        phase_acc_next = phase_acc_reg;
        out_count_next = out_count_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        // drop the held sample once it is consumed, load a new one on transfer
        if (fire) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end

        // result register: refill or clear whenever it frees
        if (out_ok) begin
            m_valid_next = fire && due;
        end
        if (fire && due) begin
            m_data_next.out_i      = lerp_i;
            m_data_next.out_q      = lerp_q;
            m_data_next.block_last = (out_count_reg == last_index);
        end

        if (fire) begin
            prev_i_next = in_data_reg.in_i;
            prev_q_next = in_data_reg.in_q;
            if (block_pos_reg == '0) begin
                // first sample after reset only seeds the block
                block_pos_next = COUNT_W'(1);
            end else begin
                if (due) begin
                    out_count_next = out_count_reg + COUNT_W'(1);
                    phase_acc_next = phase_adv;
                end
                // at block end carry this sample as position zero
                if (block_pos_reg >= block_inputs_reg) begin
                    block_pos_next = COUNT_W'(1);
                    phase_acc_next = '0;
                    out_count_next = '0;
                end else begin
                    block_pos_next = block_pos_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
            block_pos_reg <= '0;
            phase_acc_reg <= '0;
            out_count_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            m_valid_reg   <= m_valid_next;
            prev_i_reg    <= prev_i_next;
            prev_q_reg    <= prev_q_next;
            block_pos_reg <= block_pos_next;
            phase_acc_reg <= phase_acc_next;
            out_count_reg <= out_count_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

`ifndef ASSERT_OFF
    // the seeding sample never yields a result
    a_seed_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (block_pos_reg == '0) |=> !m_valid_reg)
        else $error("result produced from the seeding sample");

    // once a sample is consumed the block position is never back at zero
    a_pos_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (block_pos_reg != '0))
        else $error("block position returned to zero");

    // a due interpolation always lands in the result register
    a_due_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && due |=> m_valid_reg)
        else $error("due result lost");

    // a held sample stays put while the result side is stalled
    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_ok |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register changed during stall");
`endif

endmodule
